[hw/rtl/gvsc_pkg.sv]
// ----------------------------------------------------------------------------
// gvsc_pkg
// Shared constants and controller/datapath interface types for the
// Grain-style stream cipher.
// ----------------------------------------------------------------------------
package gvsc_pkg;

  localparam int REG_BITS     = 80;
  localparam int KEY_LO_BITS  = 64;
  localparam int KEY_HI_BITS  = 16;
  localparam int IV_BITS      = 64;
  localparam int GROUP_BITS   = 5;
  localparam int BYTE_BITS    = 8;
  localparam int INIT_ROUNDS  = 160;

  localparam int CFG_DATA_W   = 64;
  localparam int CFG_ADDR_W   = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INIT_VEC = 2'd2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_XFORM = 1'b1;

  localparam int ROUND_W = (INIT_ROUNDS > 1) ? $clog2(INIT_ROUNDS) : 1;
  localparam int CNT_W   = (ROUND_W > $clog2(BYTE_BITS)) ? ROUND_W : $clog2(BYTE_BITS);

  typedef struct packed {
    logic load;       // load key/IV into the shift registers
    logic capture;    // latch data byte and last flag
    logic step;       // advance both registers by one step
    logic init_mode;  // fold output bit back into bit 79
    logic finish;     // write the result into the output register
  } gvsc_cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
  } gvsc_stat_t;

endpackage

[hw/rtl/gvsc_ctrl.sv]
// ----------------------------------------------------------------------------
// gvsc_ctrl
// Sequencer: accepts items, runs init rounds or eight keystream steps.
// ----------------------------------------------------------------------------
module gvsc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_func,
  output logic                in_ready,
  input  gvsc_pkg::gvsc_stat_t stat,
  output gvsc_pkg::gvsc_cmd_t  cmd
);
  import gvsc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;
  localparam logic [1:0] ST_GEN  = 2'd2;

  localparam logic [CNT_W-1:0] INIT_LAST = CNT_W'(INIT_ROUNDS - 1);
  localparam logic [CNT_W-1:0] GEN_LAST  = CNT_W'(BYTE_BITS - 1);

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid & in_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          if (in_func == FUNC_LOAD) begin
            cmd.load  = 1'b1;
            state_nxt = ST_INIT;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = ST_GEN;
          end
        end
      end
      ST_INIT: begin
        cmd.step      = 1'b1;
        cmd.init_mode = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == INIT_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_GEN: begin
        if (cnt_r != GEN_LAST) begin
          cmd.step = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end else if (stat.out_free) begin
          cmd.step   = 1'b1;
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/gvsc_dp.sv]
// ----------------------------------------------------------------------------
// gvsc_dp
// Datapath: key/IV registers, NFSR and LFSR with feedback and output
// functions, keystream byte assembly and output register.
// ----------------------------------------------------------------------------
module gvsc_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [gvsc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [gvsc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [gvsc_pkg::BYTE_BITS-1:0]       in_data,
  input  logic                                 in_last,
  input  gvsc_pkg::gvsc_cmd_t                  cmd,
  output gvsc_pkg::gvsc_stat_t                 stat,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [gvsc_pkg::BYTE_BITS-1:0]       out_data,
  output logic                                 out_last
);
  import gvsc_pkg::*;

  logic [KEY_LO_BITS-1:0] key_low_r;
  logic [KEY_HI_BITS-1:0] key_high_r;
  logic [IV_BITS-1:0]     iv_r;

  logic [REG_BITS-1:0]  n, l, n_nxt, l_nxt;
  logic [REG_BITS-1:0]  key, lfsr_load;
  logic [BYTE_BITS-1:0] data_r, ks_r, ks_nxt;
  logic                 last_r;
  logic [BYTE_BITS-1:0] out_data_r;
  logic                 out_last_r, out_valid_r, out_valid_nxt;
  logic                 x0, x1, x2, x3, x4, z, nf, lf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      iv_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_KEY_LOW:  key_low_r  <= cfg_wdata;
        REG_KEY_HIGH: key_high_r <= cfg_wdata[KEY_HI_BITS-1:0];
        REG_INIT_VEC: iv_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign key = {key_high_r, key_low_r};

  always_comb begin
    lfsr_load = '0;
    lfsr_load[IV_BITS-1:0] = iv_r;
    for (int g = 0; g < KEY_HI_BITS; g++) begin
      lfsr_load[IV_BITS+g] = ~(^key[GROUP_BITS*g +: GROUP_BITS]);
    end
  end

  assign x0 = l[3];
  assign x1 = l[25];
  assign x2 = l[46];
  assign x3 = l[64];
  assign x4 = n[63];

  assign z = n[1] ^ n[2] ^ n[4] ^ n[10] ^ n[31] ^ n[43] ^ n[56]
           ^ x1 ^ x4 ^ (x0 & x3) ^ (x2 & x3) ^ (x3 & x4)
           ^ (x0 & x1 & x2) ^ (x0 & x2 & x3) ^ (x0 & x2 & x4)
           ^ (x1 & x2 & x4) ^ (x2 & x3 & x4);

  assign nf = l[0] ^ n[62] ^ n[60] ^ n[52] ^ n[45] ^ n[37] ^ n[33]
            ^ n[28] ^ n[21] ^ n[14] ^ n[9] ^ n[0]
            ^ (n[63] & n[60]) ^ (n[37] & n[33]) ^ (n[15] & n[9])
            ^ (n[60] & n[52] & n[45]) ^ (n[33] & n[28] & n[21])
            ^ (n[63] & n[45] & n[28] & n[9])
            ^ (n[60] & n[52] & n[37] & n[33])
            ^ (n[63] & n[60] & n[21] & n[15])
            ^ (n[63] & n[60] & n[52] & n[45] & n[37])
            ^ (n[33] & n[28] & n[21] & n[15] & n[9])
            ^ (n[52] & n[45] & n[37] & n[33] & n[28] & n[21]);

  assign lf = l[62] ^ l[51] ^ l[38] ^ l[23] ^ l[13] ^ l[0];

  always_comb begin
    n_nxt  = n;
    l_nxt  = l;
    ks_nxt = ks_r;
    if (cmd.load) begin
      n_nxt = key;
      l_nxt = lfsr_load;
    end else if (cmd.step) begin
      n_nxt = {nf ^ (z & cmd.init_mode), nf, n[REG_BITS-1:2]};
      l_nxt = {lf ^ (z & cmd.init_mode), lf, l[REG_BITS-1:2]};
      ks_nxt = {z, ks_r[BYTE_BITS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n <= '0;
      l <= '0;
    end else begin
      n <= n_nxt;
      l <= l_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ks_r <= ks_nxt;
    if (cmd.capture) begin
      data_r <= in_data;
      last_r <= in_last;
    end
    if (cmd.finish) begin
      out_data_r <= data_r ^ {z, ks_r[BYTE_BITS-1:1]};
      out_last_r <= last_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & ~out_ready;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign stat.out_free = ~out_valid_r | out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign out_last      = out_last_r;

endmodule

[hw/rtl/grain_variant_stream_cipher.sv]
// The shared register-clock unit steps once per cycle while an item is
// worked on, with the last step of a byte held until the output register
// is free; 8 steps per byte. A new item is accepted only once the last is done.
// A load item occupies the block for its 160 init rounds and gives no
// result. Synchronous active-low reset clears both shift registers, the
// key/IV registers and the output valid flag.
// ----------------------------------------------------------------------------
// grain_variant_stream_cipher
// Top level: stream input/output channels, configuration write port.
// ----------------------------------------------------------------------------
module grain_variant_stream_cipher (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [gvsc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [gvsc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [gvsc_pkg::BYTE_BITS-1:0]       in_tdata,   // [7:0] data_in
  input  logic                                 in_tuser,   // [0] func
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [gvsc_pkg::BYTE_BITS-1:0]       out_tdata,  // [7:0] data_out
  output logic                                 out_tlast
);
  import gvsc_pkg::*;

  gvsc_cmd_t  cmd;
  gvsc_stat_t stat;

  gvsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_func  (in_tuser),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gvsc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_tdata),
    .in_last   (in_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

[hw/rtl/gvsc_checker.sv]
// ----------------------------------------------------------------------------
// gvsc_checker
// Port-level checks for the stream cipher, bound to the top level.
// ----------------------------------------------------------------------------
module gvsc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [gvsc_pkg::BYTE_BITS-1:0]  out_tdata,
  input logic                            out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without keystream work");

  a_reset_quiet: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_tvalid)
    else $error("output valid out of reset");

endmodule

bind grain_variant_stream_cipher gvsc_checker u_gvsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
